@@ design/cwhb_pkg.sv @@
`default_nettype none

package cwhb_pkg;

    localparam int unsigned DUTY_W       = 8;
    localparam int unsigned POWER_W      = 7;
    localparam int unsigned INTERVAL_W   = 16;
    localparam int unsigned SHAPE_W      = 2;
    localparam int unsigned APB_ADDR_W   = 5;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned REG_IDX_W    = 3;
    localparam int unsigned SAMPLES_DEF  = 64;

    localparam logic [POWER_W-1:0] POWER_MAX = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 8'd255;

    // floor(x/100) == (x * RECIP100) >> RECIP_SHIFT for every x below 25600
    localparam logic [15:0]        RECIP100    = 16'd41944;
    localparam int unsigned        RECIP_SHIFT = 22;
    localparam int unsigned        SCALE_W     = 23;

    // pi/2 in Q31
    localparam logic [63:0]        HALF_PI_Q31 = 64'd3373259426;

    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_ZERO     = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DC_MODE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POLARITY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POWER    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 3'd5;

    typedef struct packed {
        logic              neg;
        logic [DUTY_W-1:0] mag;
    } sample_t;

endpackage

`default_nettype wire

@@ design/cwhb_wave_rom.sv @@
`default_nettype none

module cwhb_wave_rom #(
    parameter int unsigned SAMPLES = cwhb_pkg::SAMPLES_DEF
) (
    input  wire logic [cwhb_pkg::SHAPE_W-1:0]  shape,
    input  wire logic [$clog2(SAMPLES)-1:0]    index,
    output cwhb_pkg::sample_t                  sample
);
    import cwhb_pkg::*;

    sample_t sq_lut  [SAMPLES];
    sample_t sin_lut [SAMPLES];
    sample_t tri_lut [SAMPLES];

    for (genvar i = 0; i < SAMPLES; i++) begin : g_lut
        // square and triangle
        localparam bit          FIRST_HALF = (2 * i <= SAMPLES);
        localparam int unsigned TRI_MAG = FIRST_HALF ? (510 * i) / SAMPLES
                                                     : (510 * (SAMPLES - i)) / SAMPLES;

        // sine: fold into first quadrant, then Q31 Taylor series
        localparam int unsigned T0  = 4 * i;
        localparam bit          NEG = (T0 >= 2 * SAMPLES);
        localparam int unsigned T1  = NEG ? T0 - 2 * SAMPLES : T0;
        localparam int unsigned T   = (T1 > SAMPLES) ? 2 * SAMPLES - T1 : T1;

        localparam logic [63:0] X   = (64'(T) << 31) / SAMPLES;
        localparam logic [63:0] A   = (X * HALF_PI_Q31) >> 31;
        localparam logic [63:0] A2  = (A * A) >> 31;
        localparam logic [63:0] TM1 = ((A * A2) >> 31) / 64'd6;
        localparam logic [63:0] TM2 = ((TM1 * A2) >> 31) / 64'd20;
        localparam logic [63:0] TM3 = ((TM2 * A2) >> 31) / 64'd42;
        localparam logic [63:0] TM4 = ((TM3 * A2) >> 31) / 64'd72;
        localparam logic [63:0] TM5 = ((TM4 * A2) >> 31) / 64'd110;
        localparam logic [63:0] TM6 = ((TM5 * A2) >> 31) / 64'd156;
        localparam logic [63:0] TM7 = ((TM6 * A2) >> 31) / 64'd210;
        localparam logic [63:0] SUM = A - TM1 + TM2 - TM3 + TM4 - TM5 + TM6 - TM7;
        localparam logic [63:0] SCALED = (SUM * 64'd255) >> 31;
        localparam logic [DUTY_W-1:0] SIN_MAG = (T == 0)       ? '0 :
                                                (T >= SAMPLES) ? DUTY_FULL :
                                                SCALED[DUTY_W-1:0];

        assign sq_lut[i]  = '{neg: !FIRST_HALF, mag: DUTY_FULL};
        assign tri_lut[i] = '{neg: 1'b0, mag: TRI_MAG[DUTY_W-1:0]};
        assign sin_lut[i] = '{neg: NEG, mag: SIN_MAG};
    end

    always_comb begin
        case (shape)
            SHAPE_SQUARE:   sample = sq_lut[index];
            SHAPE_SINE:     sample = sin_lut[index];
            SHAPE_TRIANGLE: sample = tri_lut[index];
            default:        sample = '{neg: 1'b0, mag: '0};
        endcase
    end

endmodule

`default_nettype wire

@@ design/coil_waveform_hbridge_driver_core.sv @@
// Path: an accepted tick word passes the input register, then the result register, which shows its duty word.
// Throughput: one tick word per cycle while m_tready accepts duty words; the only limit is the lookup
//   plus one 8x23 multiply between the input register and the duty registers.
// Reset (aresetn low, synchronous): registers return to their defaults (wave_shape 3, others 0),
//   tick counter, sample index and held duties clear, both channels empty.
`default_nettype none

module coil_waveform_hbridge_driver_core #(
    parameter int unsigned SAMPLES = cwhb_pkg::SAMPLES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // tick word
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [0] tick, [7:1] zero
    // duty word
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // [7:0] duty_a, [15:8] duty_b
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cwhb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cwhb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cwhb_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import cwhb_pkg::*;

    localparam int unsigned IDX_W = $clog2(SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);
    localparam int unsigned PROD_W = DUTY_W + SCALE_W;

    // ---------------------------------------------------------------
    // Register file. The power scale (clamped power * 2^22/100) is
    // formed at write time so each duty in the data path takes a single multiply.
    // ---------------------------------------------------------------
    logic                   enable_reg;
    logic                   dc_mode_reg;
    logic                   polarity_reg;
    logic [POWER_W-1:0]     power_reg;
    logic [SHAPE_W-1:0]     shape_reg;
    logic [INTERVAL_W-1:0]  interval_reg;
    logic [SCALE_W-1:0]     scale_reg;

    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;
    logic [POWER_W-1:0]     power_clamped;
    logic [SCALE_W-1:0]     scale_next;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    // saturate power above 100
    assign power_clamped = (pwdata[POWER_W-1:0] > POWER_MAX) ? POWER_MAX
                                                              : pwdata[POWER_W-1:0];
    assign scale_next    = SCALE_W'(power_clamped) * SCALE_W'(RECIP100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            dc_mode_reg  <= 1'b0;
            polarity_reg <= 1'b0;
            power_reg    <= '0;
            shape_reg    <= SHAPE_ZERO;
            interval_reg <= '0;
            scale_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_DC_MODE:  dc_mode_reg  <= pwdata[0];
                REG_POLARITY: polarity_reg <= pwdata[0];
                REG_POWER: begin
                    power_reg <= pwdata[POWER_W-1:0];
                    scale_reg <= scale_next;
                end
                REG_SHAPE:    shape_reg    <= pwdata[SHAPE_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[INTERVAL_W-1:0];
                default: ;    // unmapped: ignore
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_ENABLE:   prdata[0]              = enable_reg;
            REG_DC_MODE:  prdata[0]              = dc_mode_reg;
            REG_POLARITY: prdata[0]              = polarity_reg;
            REG_POWER:    prdata[POWER_W-1:0]    = power_reg;
            REG_SHAPE:    prdata[SHAPE_W-1:0]    = shape_reg;
            REG_INTERVAL: prdata[INTERVAL_W-1:0] = interval_reg;
            default:      prdata                 = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input register -> duty registers. The held duties are
    // the output register; they only change when a word moves across.
    // ---------------------------------------------------------------
    logic in_vld_reg;
    logic tick_reg;
    logic out_vld_reg;
    logic out_free;
    logic move;

    assign out_free = !out_vld_reg || m_tready;
    assign move     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (out_free) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) tick_reg <= s_tdata[0];
    end

    // ---------------------------------------------------------------
    // Waveform pacing and duty computation
    // ---------------------------------------------------------------
    logic [INTERVAL_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [IDX_W-1:0]      index_reg, index_next;
    logic [DUTY_W-1:0]     duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0]     duty_b_reg, duty_b_next;

    sample_t                  sample;
    logic [DUTY_W+SCALE_W-1:0] ac_prod;
    logic [DUTY_W+SCALE_W-1:0] dc_prod;
    logic [DUTY_W-1:0]         ac_duty;
    logic [DUTY_W-1:0]         dc_duty;

    cwhb_wave_rom #(
        .SAMPLES (SAMPLES)
    ) u_rom (
        .shape  (shape_reg),
        .index  (index_reg),
        .sample (sample)
    );

    // duty = floor(mag * power / 100); results never exceed 255
    assign ac_prod = PROD_W'(sample.mag) * PROD_W'(scale_reg);
    assign dc_prod = PROD_W'(DUTY_FULL) * PROD_W'(scale_reg);
    assign ac_duty = ac_prod[RECIP_SHIFT +: DUTY_W];
    assign dc_duty = dc_prod[RECIP_SHIFT +: DUTY_W];

    // saturating tick count
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb begin
        elapsed_next = elapsed_reg;
        index_next   = index_reg;
        duty_a_next  = duty_a_reg;
        duty_b_next  = duty_b_reg;
        if (!enable_reg) begin
            // disabled: force off, pacing holds
            duty_a_next = '0;
            duty_b_next = '0;
        end else if (dc_mode_reg) begin
            duty_a_next = polarity_reg ? '0 : dc_duty;
            duty_b_next = polarity_reg ? dc_duty : '0;
        end else if (tick_reg) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= interval_reg) begin
                // sample step: non-negative drives A, negative drives B
                duty_a_next  = sample.neg ? '0 : ac_duty;
                duty_b_next  = sample.neg ? ac_duty : '0;
                elapsed_next = '0;
                index_next   = (index_reg == IDX_LAST) ? '0 : index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            index_reg   <= '0;
            duty_a_reg  <= '0;
            duty_b_reg  <= '0;
        end else if (move) begin
            elapsed_reg <= elapsed_next;
            index_reg   <= index_next;
            duty_a_reg  <= duty_a_next;
            duty_b_reg  <= duty_b_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {duty_b_reg, duty_a_reg};

endmodule

`default_nettype wire
